>>> rtl/mdis_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Inline markdown stripper package
// Parser modes, character codes, result types and queue sizing shared by the
// stripper modules.
// ----------------------------------------------------------------------------
package mdis_pkg;

  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChLBrk  = 8'h5B;
  localparam logic [7:0] ChRBrk  = 8'h5D;
  localparam logic [7:0] ChLPar  = 8'h28;
  localparam logic [7:0] ChRPar  = 8'h29;
  localparam logic [7:0] ChTick  = 8'h60;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChSpace = 8'h20;

  // Result queue depth; a request is taken while two entries are free.
  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  typedef enum logic [3:0] {
    ModeHash     = 4'd0,
    ModeSpace    = 4'd1,
    ModeText     = 4'd2,
    ModeStar     = 4'd3,
    ModeItalic   = 4'd4,
    ModeBold     = 4'd5,
    ModeBoldStar = 4'd6,
    ModeBang     = 4'd7,
    ModeImgAlt   = 4'd8,
    ModeLink     = 4'd9,
    ModeAfter    = 4'd10,
    ModeUrl      = 4'd11
  } mode_e;

  typedef struct packed {
    logic [7:0] chr;
    logic       present;
    logic       done;
  } mdis_res_t;

  typedef struct packed {
    logic [1:0] num;
    mdis_res_t  r0;
    mdis_res_t  r1;
  } mdis_step_t;

endpackage
`default_nettype wire

>>> rtl/mdis_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Inline markdown parser step
// Holds the parse mode and turns one request into zero, one or two results.
// ----------------------------------------------------------------------------
module mdis_parse (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         char_i,
  input  wire logic               present_i,
  input  wire logic               last_i,
  output mdis_pkg::mdis_step_t    step_o
);

  mdis_pkg::mode_e mode_q, mode_d, mode_b;
  logic            pa_v, pb_v, x_v;
  logic [7:0]      pa_c, pb_c, x_c;

  function automatic mdis_pkg::mode_e text_mode(input logic [7:0] c);
    mdis_pkg::mode_e m;
    if (c == mdis_pkg::ChStar) begin
      m = mdis_pkg::ModeStar;
    end else if (c == mdis_pkg::ChBang) begin
      m = mdis_pkg::ModeBang;
    end else if (c == mdis_pkg::ChLBrk) begin
      m = mdis_pkg::ModeLink;
    end else begin
      m = mdis_pkg::ModeText;
    end
    return m;
  endfunction

  function automatic logic text_emits(input logic [7:0] c);
    return (c != mdis_pkg::ChStar) && (c != mdis_pkg::ChBang) &&
           (c != mdis_pkg::ChLBrk) && (c != mdis_pkg::ChTick);
  endfunction

  always_comb begin
    mode_b = mode_q;
    pa_v   = 1'b0;
    pa_c   = char_i;
    pb_v   = 1'b0;
    pb_c   = char_i;
    if (present_i) begin
      unique case (mode_q)
        mdis_pkg::ModeHash: begin
          if (char_i == mdis_pkg::ChHash) begin
            mode_b = mode_q;
          end else if (char_i == mdis_pkg::ChSpace) begin
            mode_b = mdis_pkg::ModeSpace;
          end else begin
            mode_b = text_mode(char_i);
            pa_v   = text_emits(char_i);
          end
        end
        mdis_pkg::ModeSpace: begin
          if (char_i != mdis_pkg::ChSpace) begin
            mode_b = text_mode(char_i);
            pa_v   = text_emits(char_i);
          end
        end
        mdis_pkg::ModeStar: begin
          if (char_i == mdis_pkg::ChStar) begin
            mode_b = mdis_pkg::ModeBold;
          end else begin
            mode_b = mdis_pkg::ModeItalic;
            pa_v   = 1'b1;
          end
        end
        mdis_pkg::ModeItalic: begin
          if (char_i == mdis_pkg::ChStar) begin
            mode_b = mdis_pkg::ModeText;
          end else begin
            pa_v = 1'b1;
          end
        end
        mdis_pkg::ModeBold: begin
          if (char_i == mdis_pkg::ChStar) begin
            mode_b = mdis_pkg::ModeBoldStar;
          end else begin
            pa_v = 1'b1;
          end
        end
        mdis_pkg::ModeBoldStar: begin
          if (char_i == mdis_pkg::ChStar) begin
            mode_b = mdis_pkg::ModeText;
          end else begin
            mode_b = mdis_pkg::ModeBold;
            pa_v   = 1'b1;
            pa_c   = mdis_pkg::ChStar;
            pb_v   = 1'b1;
          end
        end
        mdis_pkg::ModeBang: begin
          if (char_i == mdis_pkg::ChLBrk) begin
            mode_b = mdis_pkg::ModeImgAlt;
          end else if (char_i == mdis_pkg::ChBang) begin
            pa_v = 1'b1;
            pa_c = mdis_pkg::ChBang;
          end else begin
            pa_v   = 1'b1;
            pa_c   = mdis_pkg::ChBang;
            mode_b = text_mode(char_i);
            pb_v   = text_emits(char_i);
          end
        end
        mdis_pkg::ModeImgAlt: begin
          if (char_i == mdis_pkg::ChRBrk) begin
            mode_b = mdis_pkg::ModeAfter;
          end
        end
        mdis_pkg::ModeLink: begin
          if (char_i == mdis_pkg::ChRBrk) begin
            mode_b = mdis_pkg::ModeAfter;
          end else begin
            pa_v = 1'b1;
          end
        end
        mdis_pkg::ModeAfter: begin
          if (char_i == mdis_pkg::ChLPar) begin
            mode_b = mdis_pkg::ModeUrl;
          end else begin
            mode_b = text_mode(char_i);
            pa_v   = text_emits(char_i);
          end
        end
        mdis_pkg::ModeUrl: begin
          if (char_i == mdis_pkg::ChRPar) begin
            mode_b = mdis_pkg::ModeText;
          end
        end
        default: begin
          mode_b = text_mode(char_i);
          pa_v   = text_emits(char_i);
        end
      endcase
    end
  end

  // A pending star inside bold or a pending bang is flushed at line end.
  always_comb begin
    x_v = (mode_b == mdis_pkg::ModeBoldStar) || (mode_b == mdis_pkg::ModeBang);
    x_c = (mode_b == mdis_pkg::ModeBoldStar) ? mdis_pkg::ChStar : mdis_pkg::ChBang;
  end

  always_comb begin
    step_o = '0;
    if (pa_v) begin
      step_o.num        = 2'd1;
      step_o.r0.chr     = pa_c;
      step_o.r0.present = 1'b1;
      if (pb_v) begin
        step_o.num        = 2'd2;
        step_o.r1.chr     = pb_c;
        step_o.r1.present = 1'b1;
      end else if (last_i && x_v) begin
        step_o.num        = 2'd2;
        step_o.r1.chr     = x_c;
        step_o.r1.present = 1'b1;
      end
    end else if (last_i) begin
      step_o.num = 2'd1;
      if (x_v) begin
        step_o.r0.chr     = x_c;
        step_o.r0.present = 1'b1;
      end
    end
    if (last_i) begin
      if (step_o.num == 2'd2) begin
        step_o.r1.done = 1'b1;
      end else begin
        step_o.r0.done = 1'b1;
      end
    end
  end

  always_comb begin
    mode_d = last_i ? mdis_pkg::ModeHash : mode_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mdis_pkg::ModeHash;
    end else if (accept_i) begin
      mode_q <= mode_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/markdown_inline_stripper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Inline markdown stripper
// Streams the bytes of text lines and returns them with inline markdown
// removed.
// ----------------------------------------------------------------------------
// The slave channel takes one request per line byte: tdata carries the byte,
// tuser says whether a byte is present, and tlast marks the end of a line. A
// request without a byte and without tlast changes nothing and makes no result.
// The master channel returns the stripped bytes: tdata is the byte, tuser says
// whether it is present, and tlast marks the last result of a line. A line
// that leaves no byte still ends with one result whose tuser is low.
// A request makes zero, one or two results. They are written into a four-entry
// result queue at the edge that accepts the request and are read out of it in
// order. The parser takes one request per cycle while tready is high; the
// master side sends one result per cycle while m_axis_tready is high, and a
// request that makes two results leaves as two transfers. tready is high while
// the queue has room for two results. When the receiver stalls, the queue
// fills and tready falls after a few requests; nothing is lost. Reset empties
// the queue and puts the parser at the start of a line.
// ----------------------------------------------------------------------------
module markdown_inline_stripper (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  wire logic [0:0] s_axis_tuser,   // [0] char_present
  input  wire logic       s_axis_tlast,   // line_end
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_char
  output logic [0:0]      m_axis_tuser,   // [0] out_present
  output logic            m_axis_tlast    // line_done
);

  localparam logic [mdis_pkg::CntW-1:0] ReadyMax =
    mdis_pkg::CntW'(mdis_pkg::FifoDepth - 2);

  mdis_pkg::mdis_step_t  step;
  mdis_pkg::mdis_res_t   fifo_q [mdis_pkg::FifoDepth];
  logic [mdis_pkg::PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [mdis_pkg::CntW-1:0] count_q, count_d;
  logic                  accept, pop;

  assign s_axis_tready = (count_q <= ReadyMax);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (count_q != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;

  mdis_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .char_i    (s_axis_tdata),
    .present_i (s_axis_tuser[0]),
    .last_i    (s_axis_tlast),
    .step_o    (step)
  );

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (accept) begin
      wr_ptr_d = wr_ptr_q + mdis_pkg::PtrW'(step.num);
      count_d  = count_q + mdis_pkg::CntW'(step.num);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + mdis_pkg::PtrW'(1);
      count_d  = count_d - mdis_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (step.num != 2'd0)) begin
      fifo_q[wr_ptr_q] <= step.r0;
    end
    if (accept && (step.num == 2'd2)) begin
      fifo_q[wr_ptr_q + mdis_pkg::PtrW'(1)] <= step.r1;
    end
  end

  assign m_axis_tdata    = fifo_q[rd_ptr_q].chr;
  assign m_axis_tuser[0] = fifo_q[rd_ptr_q].present;
  assign m_axis_tlast    = fifo_q[rd_ptr_q].done;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mdis_pkg::CntW'(mdis_pkg::FifoDepth))
    else $error("Result queue holds more entries than its depth.");

  a_line_end_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |-> (step.num != 2'd0))
    else $error("A line end produced no result.");

  a_count_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !pop) |=> (count_q == $past(count_q) + mdis_pkg::CntW'($past(step.num))))
    else $error("Queue fill count does not follow the written results.");

  a_ptr_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != mdis_pkg::CntW'(mdis_pkg::FifoDepth)) |->
    (mdis_pkg::PtrW'(wr_ptr_q - rd_ptr_q) == mdis_pkg::PtrW'(count_q)))
    else $error("Queue pointers disagree with the fill count.");

endmodule
`default_nettype wire
